FILE: design/sm4_pkg.sv
package sm4_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] blk_t;

  typedef struct packed {
    logic fwd;
    logic bwd;
  } chain_ctl_t;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd1;

  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  function automatic word_t sub_word(word_t v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic word_t lin_data(word_t b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic word_t lin_key(word_t b);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // Byte j of chain constant i is (4*i + j) * 7 modulo 256.
  function automatic word_t chain_const(logic [7:0] i);
    word_t w;
    logic [9:0] base;
    w = '0;
    base = {i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 10'(j)) * 10'd7)};
    end
    return w;
  endfunction

endpackage

FILE: design/sm4_round.sv
module sm4_rnd_unit (
  input  sm4_pkg::blk_t  w,
  input  sm4_pkg::word_t addend,
  input  logic           key_mode,
  output sm4_pkg::word_t nx
);
  import sm4_pkg::*;

  word_t sb;

  always_comb begin
    sb = sub_word(w[1] ^ w[2] ^ w[3] ^ addend);
    nx = w[0] ^ (key_mode ? lin_key(sb) : lin_data(sb));
  end

endmodule

FILE: design/sm4_key_stage.sv
module sm4_key_stage (
  input  logic                clk,
  input  sm4_pkg::chain_ctl_t ctl,
  input  sm4_pkg::word_t      from_next,
  input  sm4_pkg::word_t      from_prev,
  output sm4_pkg::word_t      q
);
  import sm4_pkg::*;

  word_t rk_r;

  always_ff @(posedge clk) begin
    if (ctl.fwd) begin
      rk_r <= from_next;
    end else if (ctl.bwd) begin
      rk_r <= from_prev;
    end
  end

  assign q = rk_r;

endmodule

FILE: design/sm4_block_cipher_core.sv
// SM4 block cipher core, electronic codebook form.
// The input channel (in_) carries one 128-bit block in tdata and the
// direction in tuser (0 encrypts, 1 decrypts). The output channel (out_)
// carries the 128-bit result. The key is written through the cfg_ port:
// index 0 sets the upper 64 key bits, index 1 the lower 64 bits; other
// indexes are accepted and ignored.
// Every valid key write, and reset, starts a key expansion, during
// which neither a block nor a key word is accepted. The round keys live
// in a ring of 32 stages which turns one place per cycle while a key is
// expanded or a block runs. A block runs 32 rounds through one shared
// round unit, one round per cycle; the core takes no new block until the
// result is loaded into the output register, where out_tvalid rises.
// The result sits in an output register; a stalled receiver does not stop
// the next block from being accepted, but a finished block waits in the
// core until the output register is free.
// Reset is synchronous and active low; it drops out_tvalid and loads the
// all-zero key.
module sm4_block_cipher_core #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [127:0]                     in_tdata,  // block_high, block_low
  input  logic                             in_tuser,  // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [127:0]                     out_tdata, // result_high, result_low
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sm4_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                      cfg_data
);
  import sm4_pkg::*;

  localparam int CW = $clog2(ROUND_COUNT);
  localparam logic [CW-1:0] LAST = CW'(ROUND_COUNT - 1);

  typedef enum logic [2:0] {
    S_KEYLOAD,
    S_EXPAND,
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    cnt_r;
  blk_t             w_r;
  logic             dec_r;
  logic [63:0]      key_high_r;
  logic [63:0]      key_low_r;
  logic             out_valid_r;
  logic [127:0]     out_data_r;

  word_t            rk_q [ROUND_COUNT];
  word_t            rk_next [ROUND_COUNT];
  word_t            rk_prev [ROUND_COUNT];
  chain_ctl_t       ctl;
  word_t            addend;
  word_t            nx;
  logic             key_mode;
  logic             in_acc;
  logic             cfg_acc;
  logic             out_free;
  logic             out_load;

  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;
  assign key_mode  = (state_r == S_EXPAND);
  assign out_load  = out_free &&
                     (((state_r == S_RUN) && (cnt_r == LAST)) || (state_r == S_HOLD));

  always_comb begin
    ctl.fwd = (state_r == S_EXPAND) || ((state_r == S_RUN) && !dec_r);
    ctl.bwd = (state_r == S_RUN) && dec_r;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      rk_prev[i] = (i == 0) ? rk_q[ROUND_COUNT-1] : rk_q[i-1];
      if (i == ROUND_COUNT - 1) begin
        rk_next[i] = key_mode ? nx : rk_q[0];
      end else begin
        rk_next[i] = rk_q[i+1];
      end
    end
    if (key_mode) begin
      addend = chain_const(8'(cnt_r));
    end else begin
      addend = dec_r ? rk_q[ROUND_COUNT-1] : rk_q[0];
    end
  end

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_key
    sm4_key_stage u_stage (
      .clk       (clk),
      .ctl       (ctl),
      .from_next (rk_next[g]),
      .from_prev (rk_prev[g]),
      .q         (rk_q[g])
    );
  end

  sm4_rnd_unit u_round (
    .w        (w_r),
    .addend   (addend),
    .key_mode (key_mode),
    .nx       (nx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_KEYLOAD;
      cnt_r       <= '0;
      key_high_r  <= '0;
      key_low_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_KEYLOAD: begin
          w_r[0]  <= key_high_r[63:32] ^ FK0;
          w_r[1]  <= key_high_r[31:0] ^ FK1;
          w_r[2]  <= key_low_r[63:32] ^ FK2;
          w_r[3]  <= key_low_r[31:0] ^ FK3;
          cnt_r   <= '0;
          state_r <= S_EXPAND;
        end
        S_EXPAND: begin
          w_r   <= {nx, w_r[3], w_r[2], w_r[1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == CFG_KEY_HIGH) begin
              key_high_r <= cfg_data;
              state_r    <= S_KEYLOAD;
            end else if (cfg_index == CFG_KEY_LOW) begin
              key_low_r <= cfg_data;
              state_r   <= S_KEYLOAD;
            end
          end else if (in_acc) begin
            w_r     <= {in_tdata[95:64], in_tdata[127:96], in_tdata[31:0], in_tdata[63:32]};
            dec_r   <= in_tuser;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          w_r   <= {nx, w_r[3], w_r[2], w_r[1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            if (out_free) begin
              out_data_r  <= {w_r[1], w_r[2], w_r[3], nx};
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_data_r  <= {w_r[0], w_r[1], w_r[2], w_r[3]};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_KEYLOAD;
        end
      endcase
    end
  end

  // Result high half (x3, x2) in the low 64 bits, low half (x1, x0) above.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[95:64], out_data_r[127:96],
                       out_data_r[31:0], out_data_r[63:32]};

  a_in_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_RUN && cnt_r == '0)
    else $error("accepted block did not start the rounds");

  a_key_write_expands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)
    |=> state_r == S_KEYLOAD)
    else $error("key write did not start a key expansion");

  a_expand_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXPAND && cnt_r == LAST |=> state_r == S_IDLE)
    else $error("key expansion did not end after the last round");

  a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD && out_valid_r && !out_tready |=> state_r == S_HOLD)
    else $error("finished block left while the output register was full");

  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready && !cfg_ready)
    else $error("channel open while the core is busy");

endmodule
